FILE: design/rc4bk_pkg.sv
// ----------------------------------------------------------------------------
// rc4bk_pkg
// Shared types and constants for the bit-keyed RC4 stream cipher core.
// ----------------------------------------------------------------------------
package rc4bk_pkg;

  localparam int PERM_DEPTH = 256;
  localparam int ADDR_W     = $clog2(PERM_DEPTH);
  localparam int BYTE_W     = 8;
  localparam int KEY_BITS   = 64;
  localparam int KEY_IDX_W  = $clog2(KEY_BITS);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [KEY_BITS-1:0] key_t;

  // Permutation memory access from the sequencer
  typedef struct packed {
    logic  we;
    addr_t waddr;
    byte_t wdata;
    addr_t raddr;
  } ram_req_t;

  // Operands of the shared byte adder
  typedef struct packed {
    byte_t a;
    byte_t b;
    logic  cin;
  } alu_op_t;

endpackage

FILE: design/rc4bk_perm_ram.sv
// ----------------------------------------------------------------------------
// rc4bk_perm_ram
// 256 x 8 permutation memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rc4bk_perm_ram
  import rc4bk_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output byte_t    rd_data
);

  byte_t mem [PERM_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[req.raddr];
  end

endmodule

FILE: design/rc4bk_alu.sv
// ----------------------------------------------------------------------------
// rc4bk_alu
// Shared modulo-256 byte adder with carry in, used for the i, j and keystream
// index updates. The fill and swap counter n has its own increment.
module rc4bk_alu
  import rc4bk_pkg::*;
(
  input  alu_op_t op,
  output byte_t   sum
);

  logic [BYTE_W:0] full_sum;

  // carry out of bit 7 is dropped (mod 256)
  assign full_sum = {1'b0, op.a} + {1'b0, op.b} + {{BYTE_W{1'b0}}, op.cin};
  assign sum      = full_sum[BYTE_W-1:0];

endmodule

FILE: design/rc4_bitkey_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// rc4_bitkey_stream_cipher_core
// Bit-keyed RC4 stream cipher: key schedule and keystream XOR under one
// sequencer sharing a single byte adder and one permutation memory.
// ----------------------------------------------------------------------------
// Sequence: a keyed byte runs ST_PR_I to ST_PR_OUT before out_tvalid; a key
//   schedule first runs the identity fill, then ST_KS_RDN to ST_KS_WRJ per
//   entry. A new byte is taken only when idle; each byte makes the serial
//   memory accesses of its swap (read i, read j, two writes, keystream read).
// Reset: rst_n synchronous active low; clears n, i, j, keyed flag, key
//   register and output valid. The permutation memory is not cleared.
// ----------------------------------------------------------------------------
module rc4_bitkey_stream_cipher_core
  import rc4bk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] start_message
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] result_byte
  // key register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data    // [63:0] cipher_key
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RDN,
    ST_KS_ADDJ,
    ST_KS_WRN,
    ST_KS_WRJ,
    ST_PR_I,
    ST_PR_J,
    ST_PR_WI,
    ST_PR_WJ,
    ST_PR_KS,
    ST_PR_OUT
  } state_t;

  state_t   state_r;
  key_t     key_r;
  logic     keyed_r;
  addr_t    n_r;
  byte_t    i_r;
  byte_t    j_r;
  byte_t    si_r;
  byte_t    sj_r;
  byte_t    k_r;
  byte_t    data_r;
  logic     out_valid_r;
  byte_t    out_data_r;

  ram_req_t ram_req;
  byte_t    rd_data;
  alu_op_t  alu_op;
  byte_t    alu_sum;
  logic     key_bit;

  rc4bk_perm_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  rc4bk_alu u_alu (
    .op  (alu_op),
    .sum (alu_sum)
  );

  assign key_bit    = key_r[n_r[KEY_IDX_W-1:0]];
  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // adder operand select
  always_comb begin
    alu_op = '{a: j_r, b: rd_data, cin: 1'b0};
    unique case (state_r)
      ST_KS_ADDJ: alu_op = '{a: j_r, b: rd_data, cin: key_bit};
      ST_PR_I:    alu_op = '{a: i_r, b: '0, cin: 1'b1};
      ST_PR_J:    alu_op = '{a: j_r, b: rd_data, cin: 1'b0};
      ST_PR_WJ:   alu_op = '{a: si_r, b: sj_r, cin: 1'b0};
      default:    alu_op = '{a: j_r, b: rd_data, cin: 1'b0};
    endcase
  end

  // memory request per state
  always_comb begin
    ram_req = '{we: 1'b0, waddr: n_r, wdata: n_r, raddr: n_r};
    unique case (state_r)
      ST_FILL:    ram_req = '{we: 1'b1, waddr: n_r, wdata: n_r, raddr: n_r};
      ST_KS_RDN:  ram_req = '{we: 1'b0, waddr: n_r, wdata: n_r, raddr: n_r};
      ST_KS_ADDJ: ram_req = '{we: 1'b0, waddr: n_r, wdata: n_r, raddr: alu_sum};
      ST_KS_WRN:  ram_req = '{we: 1'b1, waddr: n_r, wdata: rd_data, raddr: j_r};
      ST_KS_WRJ:  ram_req = '{we: 1'b1, waddr: j_r, wdata: si_r, raddr: j_r};
      ST_PR_I:    ram_req = '{we: 1'b0, waddr: i_r, wdata: si_r, raddr: alu_sum};
      ST_PR_J:    ram_req = '{we: 1'b0, waddr: i_r, wdata: si_r, raddr: alu_sum};
      ST_PR_WI:   ram_req = '{we: 1'b1, waddr: i_r, wdata: rd_data, raddr: j_r};
      ST_PR_WJ:   ram_req = '{we: 1'b1, waddr: j_r, wdata: si_r, raddr: j_r};
      ST_PR_KS:   ram_req = '{we: 1'b0, waddr: j_r, wdata: si_r, raddr: k_r};
      ST_PR_OUT:  ram_req = '{we: 1'b0, waddr: j_r, wdata: si_r, raddr: k_r};
      default:    ram_req = '{we: 1'b0, waddr: n_r, wdata: n_r, raddr: n_r};
    endcase
  end

  // key register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      key_r <= cfg_data;
    end
  end

  // sequencer, indices and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      keyed_r     <= 1'b0;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; the output state reloads the register itself
      if (out_valid_r && out_tready && state_r != ST_PR_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            data_r <= in_tdata;
            if (in_tuser || !keyed_r) begin
              n_r     <= '0;
              j_r     <= '0;
              state_r <= ST_FILL;
            end else begin
              state_r <= ST_PR_I;
            end
          end
        end
        // identity fill, one entry per cycle
        ST_FILL: begin
          n_r <= n_r + addr_t'(1);
          if (n_r == addr_t'(PERM_DEPTH - 1)) begin
            state_r <= ST_KS_RDN;
          end
        end
        // key schedule swap step n
        ST_KS_RDN: state_r <= ST_KS_ADDJ;
        ST_KS_ADDJ: begin
          si_r    <= rd_data;
          j_r     <= alu_sum;
          state_r <= ST_KS_WRN;
        end
        ST_KS_WRN: state_r <= ST_KS_WRJ;
        ST_KS_WRJ: begin
          n_r <= n_r + addr_t'(1);
          if (n_r == addr_t'(PERM_DEPTH - 1)) begin
            i_r     <= '0;
            j_r     <= '0;
            keyed_r <= 1'b1;
            state_r <= ST_PR_I;
          end else begin
            state_r <= ST_KS_RDN;
          end
        end
        // keystream byte
        ST_PR_I: begin
          i_r     <= alu_sum;
          state_r <= ST_PR_J;
        end
        ST_PR_J: begin
          si_r    <= rd_data;
          j_r     <= alu_sum;
          state_r <= ST_PR_WI;
        end
        ST_PR_WI: begin
          sj_r    <= rd_data;
          state_r <= ST_PR_WJ;
        end
        ST_PR_WJ: begin
          k_r     <= alu_sum;
          state_r <= ST_PR_KS;
        end
        ST_PR_KS: state_r <= ST_PR_OUT;
        // hold until the output register is free
        ST_PR_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= data_r ^ rd_data;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/rc4bk_checker.sv
// ----------------------------------------------------------------------------
// rc4bk_checker
// Port-level assertions for the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
module rc4bk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       cfg_ready
);

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one byte in flight: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous byte in flight");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready) && in_tready)
    else $error("result appeared without work");

  // key register is always writable
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("key write port not ready");

endmodule

bind rc4_bitkey_stream_cipher_core rc4bk_checker u_rc4bk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
